// ===== rtl/gsa_pkg.sv =====
// Package for the generational slot allocator: request and response types,
// function and status codes, and the controller/datapath interface structs.
// No dependencies.
package gsa_pkg;

  localparam int SLOT_COUNT_DEFAULT = 4096;

  localparam logic [1:0] FUNC_ALLOC        = 2'd0;
  localparam logic [1:0] FUNC_FREE         = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP       = 2'd2;
  localparam logic [1:0] FUNC_LOOKUP_TYPED = 2'd3;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
  localparam logic [1:0] STATUS_INVALID   = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] handle_index;
    logic [31:0] handle_generation;
    logic [31:0] payload_in;
    logic [3:0]  res_type;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] slot_out;
    logic [31:0] generation_out;
    logic [31:0] payload_out;
    logic [12:0] slots_free;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rsp_hold;
  } sts_t;

endpackage

// ===== rtl/gsa_ctrl.sv =====
// Controller of the generational slot allocator: a two-state sequencer that
// takes a request, then executes it once the response register is free.
// Depends on gsa_pkg.
module gsa_ctrl
  import gsa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [0:0] ST_IDLE = 1'b0;
  localparam logic [0:0] ST_EXEC = 1'b1;

  logic [0:0] state;
  logic [0:0] state_next;

  always_comb begin
    state_next  = state;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.rsp_hold) begin
          cmd.execute = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/gsa_datapath.sv =====
// Datapath of the generational slot allocator: slot memory, free-list head,
// counters, handle check and the response register.
// Depends on gsa_pkg.
module gsa_datapath
  import gsa_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  // One slot entry: alive flag, type, generation, and link or payload word.
  typedef struct packed {
    logic        alive;
    logic [3:0]  kind;
    logic [31:0] gen;
    logic [31:0] word;
  } entry_t;

  entry_t mem [SLOT_COUNT];
  entry_t rdata;

  req_t        cur;
  logic [IW-1:0] raddr;
  logic [CW-1:0] free_top;
  logic [CW-1:0] free_total;
  logic [CW-1:0] bump;
  logic [31:0]   seed;

  logic [CW-1:0] free_top_next;
  logic [CW-1:0] free_total_next;
  logic [CW-1:0] bump_next;
  logic [31:0]   seed_next;
  logic [IW-1:0] rd_addr;
  logic          wr_en;
  entry_t        wdata;
  rsp_t          rsp_next;

  logic          fresh;
  logic          rd_alive;
  logic [CW-1:0] rd_link;
  logic          handle_ok;
  logic [31:0]   new_gen;

  assign rd_addr = (req.func == FUNC_ALLOC) ? IW'(free_top) : IW'(req.handle_index);

  // Entries at or above the bump count were never written since reset: they
  // are treated as dead and as holding the initial ascending chain.
  assign fresh    = (CW'(raddr) >= bump);
  assign rd_alive = fresh ? 1'b0 : rdata.alive;
  assign rd_link  = fresh ? (CW'(raddr) + CW'(1)) : CW'(rdata.word);

  assign handle_ok = (cur.handle_generation != 32'd0) &&
                     (32'(cur.handle_index) < SLOT_COUNT) &&
                     (rdata.gen == cur.handle_generation) && rd_alive;

  assign sts.rsp_hold = rsp_valid && rsp_stall;

  always_comb begin
    free_top_next   = free_top;
    free_total_next = free_total;
    bump_next       = bump;
    seed_next       = seed;
    wr_en           = 1'b0;
    wdata           = rdata;
    new_gen         = seed;
    rsp_next.status         = STATUS_OK;
    rsp_next.slot_out       = cur.handle_index;
    rsp_next.generation_out = 32'd0;
    rsp_next.payload_out    = 32'd0;

    // The counter skips zero: a wrapped seed hands out one and moves to two.
    if (seed == 32'd0) begin
      new_gen = 32'd1;
    end

    case (cur.func)
      FUNC_ALLOC: begin
        if (free_total == CW'(0) || 32'(free_top) >= SLOT_COUNT) begin
          rsp_next.status = STATUS_EXHAUSTED;
        end else begin
          seed_next       = (seed == 32'd0) ? 32'd2 : seed + 32'd1;
          free_top_next   = rd_link;
          free_total_next = free_total - CW'(1);
          if (fresh) begin
            bump_next = bump + CW'(1);
          end
          wr_en       = 1'b1;
          wdata.alive = 1'b1;
          wdata.kind  = cur.res_type;
          wdata.gen   = new_gen;
          wdata.word  = cur.payload_in;
          rsp_next.slot_out       = 12'(free_top);
          rsp_next.generation_out = new_gen;
        end
      end
      FUNC_FREE: begin
        if (handle_ok) begin
          wr_en           = 1'b1;
          wdata.alive     = 1'b0;
          wdata.word      = 32'(free_top);
          free_top_next   = CW'(cur.handle_index);
          free_total_next = free_total + CW'(1);
        end else begin
          rsp_next.status = STATUS_INVALID;
        end
      end
      default: begin
        if (handle_ok && (cur.func == FUNC_LOOKUP || rdata.kind == cur.res_type)) begin
          rsp_next.payload_out = rdata.word;
        end else begin
          rsp_next.status = STATUS_INVALID;
        end
      end
    endcase

    rsp_next.slots_free = 13'(free_total_next);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rdata <= mem[rd_addr];
      cur   <= req;
      raddr <= rd_addr;
    end
    if (cmd.execute && wr_en) begin
      mem[raddr] <= wdata;
    end
    if (cmd.execute) begin
      rsp <= rsp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_top   <= CW'(0);
      free_total <= CW'(SLOT_COUNT);
      bump       <= CW'(0);
      seed       <= 32'd1;
      rsp_valid  <= 1'b0;
    end else begin
      if (cmd.execute) begin
        free_top   <= free_top_next;
        free_total <= free_total_next;
        bump       <= bump_next;
        seed       <= seed_next;
        rsp_valid  <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/generational_slot_allocator_unit.sv =====
// Generational slot allocator, top level. A taken request has its slot memory
// entry read into a register, then executes, writing the response register and
// the entry update through its single port; only then is a new request taken.
// A stalled response delays execution until the response register frees up.
// Synchronous reset clears the counters and free-list head at once; the slot
// memory is not swept, since a fill count marks slots never written.
module generational_slot_allocator_unit
  import gsa_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  cmd_t cmd;
  sts_t sts;

  gsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gsa_datapath #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for generational_slot_allocator_unit: drives requests through
// the valid/stall channel and checks every response against a behavioral slot pool.
// Depends on gsa_pkg and the allocator RTL.
`timescale 1ns / 100ps

import gsa_pkg::*;

class slot_ledger;
  bit [31:0]   link_word[SLOT_COUNT_DEFAULT];
  bit [31:0]   slot_gen[SLOT_COUNT_DEFAULT];
  bit          slot_live[SLOT_COUNT_DEFAULT];
  bit [3:0]    slot_type[SLOT_COUNT_DEFAULT];
  int unsigned list_top;
  int unsigned open_count;
  int unsigned high_water;
  bit [31:0]   gen_counter;
  rsp_t        expected_q[$];
  int unsigned mismatches;

  function new();
    for (int i = 0; i < SLOT_COUNT_DEFAULT; i++) begin
      link_word[i] = i + 1;
      slot_gen[i]  = '0;
      slot_live[i] = 1'b0;
      slot_type[i] = '0;
    end
    list_top    = 0;
    open_count  = SLOT_COUNT_DEFAULT;
    high_water  = 0;
    gen_counter = 32'd1;
    mismatches  = 0;
  endfunction

  function bit handle_live(int unsigned idx, bit [31:0] gen);
    if (gen == 0 || idx >= SLOT_COUNT_DEFAULT) return 1'b0;
    return slot_gen[idx] == gen && slot_live[idx];
  endfunction

  // Applies one accepted request to the pool and queues the response it must produce.
  function void note_request(req_t r);
    rsp_t        e;
    bit [31:0]   g;
    int unsigned idx;
    e = '0;
    e.status = STATUS_OK;
    e.slot_out = r.handle_index;
    idx = 32'(r.handle_index);
    case (r.func)
      FUNC_ALLOC: begin
        idx = list_top;
        if (open_count == 0 || idx >= SLOT_COUNT_DEFAULT) begin
          e.status = STATUS_EXHAUSTED;
        end else begin
          g = gen_counter;
          gen_counter++;
          // Generation zero is reserved, so a wrap skips over it.
          if (g == 0) begin
            g = gen_counter;
            gen_counter++;
            if (g == 0) g = 32'd1;
          end
          list_top = link_word[idx];
          open_count--;
          slot_live[idx] = 1'b1;
          slot_gen[idx]  = g;
          link_word[idx] = r.payload_in;
          slot_type[idx] = r.res_type;
          if (idx >= high_water) high_water = idx + 1;
          e.slot_out = idx[11:0];
          e.generation_out = g;
        end
      end
      FUNC_FREE: begin
        if (handle_live(idx, r.handle_generation)) begin
          slot_live[idx] = 1'b0;
          link_word[idx] = list_top;
          list_top = idx;
          open_count++;
        end else begin
          e.status = STATUS_INVALID;
        end
      end
      default: begin
        if (handle_live(idx, r.handle_generation) &&
            (r.func == FUNC_LOOKUP || slot_type[idx] == r.res_type)) begin
          e.payload_out = link_word[idx];
        end else begin
          e.status = STATUS_INVALID;
        end
      end
    endcase
    e.slots_free = open_count[12:0];
    expected_q.push_back(e);
  endfunction

  function void flag(string field, logic [63:0] want, logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) $display("mismatch on %s: expected %h, got %h", field, want, got);
  endfunction

  function void check_response(rsp_t got);
    rsp_t want;
    if (expected_q.size() == 0) begin
      flag("slot_out of a response with no request pending", '0, 64'(got.slot_out));
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status) flag("status", 64'(want.status), 64'(got.status));
    if (got.slot_out !== want.slot_out) flag("slot_out", 64'(want.slot_out), 64'(got.slot_out));
    if (got.generation_out !== want.generation_out)
      flag("generation_out", 64'(want.generation_out), 64'(got.generation_out));
    if (got.payload_out !== want.payload_out)
      flag("payload_out", 64'(want.payload_out), 64'(got.payload_out));
    if (got.slots_free !== want.slots_free)
      flag("slots_free", 64'(want.slots_free), 64'(got.slots_free));
  endfunction

  // Prefers a live slot so that frees and lookups mostly hit real handles.
  function int unsigned pick_live();
    int unsigned idx;
    if (high_water == 0) return $urandom_range(SLOT_COUNT_DEFAULT - 1);
    repeat (32) begin
      idx = $urandom_range(high_water - 1);
      if (slot_live[idx]) return idx;
    end
    return $urandom_range(high_water - 1);
  endfunction

  function bit [31:0] generation_of(int unsigned idx);
    return slot_gen[idx];
  endfunction

  function bit [3:0] kind_of(int unsigned idx);
    return slot_type[idx];
  endfunction

  function int unsigned free_slots();
    return open_count;
  endfunction

  function int unsigned outstanding();
    return expected_q.size();
  endfunction

  function bit failed();
    return mismatches != 0 || expected_q.size() != 0;
  endfunction
endclass

module testbench;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req_word = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp_word;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_order = 0;
  int unsigned hold_left = 0;

  slot_ledger ledger = new();

  generational_slot_allocator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp_word)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver side: random stalls, or a long counted hold-off when one is ordered.
  always @(negedge clk) begin
    if (hold_order != 0) begin
      hold_left = hold_order;
      hold_order = 0;
    end
    if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left--;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) ledger.check_response(rsp_word);
  end

  function automatic req_t make_req(logic [1:0] func, logic [11:0] idx, logic [31:0] gen,
                                    logic [31:0] pay, logic [3:0] kind);
    req_t r;
    r.func = func;
    r.handle_index = idx;
    r.handle_generation = gen;
    r.payload_in = pay;
    r.res_type = kind;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t        r;
    int unsigned roll;
    int unsigned pick;
    int unsigned idx;
    roll = $urandom_range(99);
    r = make_req(FUNC_ALLOC, 12'($urandom_range(4095)), $urandom, $urandom,
                 4'($urandom_range(9)));
    if (roll >= 35) begin
      r.func = roll < 60 ? FUNC_FREE : roll < 80 ? FUNC_LOOKUP : FUNC_LOOKUP_TYPED;
      pick = $urandom_range(99);
      if (pick < 80) begin
        idx = ledger.pick_live();
        r.handle_index = idx[11:0];
        r.handle_generation = ledger.generation_of(idx);
        // An older generation of the same slot makes a stale handle.
        if (pick >= 70) r.handle_generation = r.handle_generation - 32'($urandom_range(3)) - 1;
      end else if (pick < 90) begin
        r.handle_generation = ledger.generation_of(32'(r.handle_index));
      end
      if (r.func == FUNC_LOOKUP_TYPED && $urandom_range(99) < 70)
        r.res_type = ledger.kind_of(32'(r.handle_index));
    end
    return r;
  endfunction

  // Entered and left at a falling edge; the request is logged when it is taken.
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_word <= r;
    do @(posedge clk); while (req_stall);
    ledger.note_request(r);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int n;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed requests. Generations run 1, 2, 3 ... from reset.
    send_request(make_req(FUNC_LOOKUP, 12'd0, 32'd1, 32'd0, 4'd0));
    send_request(make_req(FUNC_ALLOC, 12'd4095, 32'd0, 32'h0000_0000, 4'd0));
    send_request(make_req(FUNC_ALLOC, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd9));
    send_request(make_req(FUNC_ALLOC, 12'd2730, 32'd0, 32'hA5A5_5A5A, 4'd8));
    send_request(make_req(FUNC_LOOKUP, 12'd0, 32'd1, 32'hFFFF_FFFF, 4'd0));
    send_request(make_req(FUNC_LOOKUP, 12'd1, 32'd2, 32'd0, 4'd0));
    send_request(make_req(FUNC_LOOKUP_TYPED, 12'd1, 32'd2, 32'd0, 4'd9));
    send_request(make_req(FUNC_LOOKUP_TYPED, 12'd2, 32'd3, 32'd0, 4'd7));
    send_request(make_req(FUNC_LOOKUP, 12'd1, 32'd0, 32'd0, 4'd0));
    send_request(make_req(FUNC_LOOKUP, 12'd1, 32'hFFFF_FFFF, 32'd0, 4'd0));
    send_request(make_req(FUNC_FREE, 12'd1, 32'd2, 32'hFFFF_FFFF, 4'd9));
    send_request(make_req(FUNC_FREE, 12'd1, 32'd2, 32'd0, 4'd0));
    send_request(make_req(FUNC_LOOKUP, 12'd1, 32'd2, 32'd0, 4'd0));
    send_request(make_req(FUNC_ALLOC, 12'd0, 32'd0, 32'h1234_5678, 4'd5));
    send_request(make_req(FUNC_LOOKUP_TYPED, 12'd1, 32'd2, 32'd0, 4'd5));
    send_request(make_req(FUNC_FREE, 12'd4095, 32'hFFFF_FFFF, 32'd0, 4'd0));
    send_request(make_req(FUNC_LOOKUP_TYPED, 12'd4095, 32'd0, 32'd0, 4'd9));
    send_request(make_req(FUNC_FREE, 12'd0, 32'd1, 32'd0, 4'd0));
    send_request(make_req(FUNC_FREE, 12'd2, 32'd3, 32'd0, 4'd0));
    send_request(make_req(FUNC_FREE, 12'd1, 32'd4, 32'd0, 4'd0));
    send_request(make_req(FUNC_ALLOC, 12'd0, 32'd0, 32'h8000_0001, 4'd1));
    send_request(make_req(FUNC_ALLOC, 12'd0, 32'd0, 32'h7FFF_FFFE, 4'd2));
    send_request(make_req(FUNC_ALLOC, 12'd0, 32'd0, 32'h0F0F_F0F0, 4'd4));
    send_request(make_req(FUNC_LOOKUP_TYPED, 12'd0, 32'd7, 32'd0, 4'd4));
    wait_drained();

    // Random mix under three idling patterns, each ending with a full drain.
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 17 : (p == 1) ? 83 : 0;
      recv_idle_pct = (p == 0) ? 83 : (p == 1) ? 17 : 0;
      for (n = 0; n < 430; n++) begin
        if (p == 2 && n == 100) hold_order = 64;
        send_request(random_request());
      end
      wait_drained();
    end

    // A last random run with moderate receiver stalls.
    recv_idle_pct = 30;
    repeat (60) send_request(random_request());

    wait_drained();
    repeat (8) @(posedge clk);
    if (!ledger.failed()) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/gsa_pkg.sv
rtl/gsa_ctrl.sv
rtl/gsa_datapath.sv
rtl/generational_slot_allocator_unit.sv
tb/testbench.sv
